// ===== rtl/snhf_pkg.sv =====
// shared types, constants and helpers for the static next-hop forwarder
// no dependencies; imported by snhf_decide and the top level
`default_nettype none

package snhf_pkg;

  localparam int unsigned TABLE_ENTRIES_DEFAULT = 256;

  localparam logic [7:0] ADDR_BROADCAST = 8'hFF;

  // verdict codes
  localparam logic [2:0] VERDICT_FORWARD    = 3'd0;
  localparam logic [2:0] VERDICT_DELIVER    = 3'd1;
  localparam logic [2:0] VERDICT_DROP_LOOP  = 3'd2;
  localparam logic [2:0] VERDICT_NOT_MINE   = 3'd3;
  localparam logic [2:0] VERDICT_NO_ROUTE   = 3'd4;
  localparam logic [2:0] VERDICT_ROUTE_ACK  = 3'd5;

  // input item action codes
  localparam logic ACTION_PACKET = 1'b0;
  localparam logic ACTION_ROUTE  = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_WIDTH = 1;
  localparam int unsigned CFG_DATA_WIDTH  = 8;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NODE_ADDRESS       = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ROUTE_HEADER_BYTES = 1'd1;

  typedef struct packed {
    logic        action;
    logic [7:0]  source_address;
    logic [7:0]  destination_address;
    logic [7:0]  incoming_next_hop;
    logic [7:0]  forward_count;
    logic [15:0] packet_bytes;
    logic        going_up;
    logic [7:0]  route_owner;
    logic [7:0]  route_destination;
    logic [7:0]  route_hop;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [7:0]  outgoing_next_hop;
    logic [7:0]  new_forward_count;
    logic [15:0] new_packet_bytes;
    logic        route_stored;
  } rsp_item_t;

  // one table word: valid flag and stored hop
  typedef struct packed {
    logic       valid;
    logic [7:0] hop;
  } hop_entry_t;

  // true when an 8-bit address has a slot in a table of the given size
  function automatic logic addr_in_table(logic [7:0] addr, int unsigned entries);
    return 32'(addr) < entries;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/snhf_ram.sv =====
// generic single-port ram with registered read (read-first)
// no dependencies
`default_nettype none

module snhf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/snhf_decide.sv =====
// verdict and result field logic for one registered item plus its table word
// depends on snhf_pkg
`default_nettype none

module snhf_decide
  import snhf_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
  input  wire req_item_t  item,
  input  wire hop_entry_t entry,
  input  wire logic [7:0] node_address,
  input  wire logic [7:0] route_header_bytes,
  output rsp_item_t       result
);

  logic        from_here;
  logic [7:0]  fc_inc;
  logic [16:0] size_sum;
  logic [15:0] size_new;
  logic        for_here;
  logic        route_hit;

  always_comb begin
    from_here = item.source_address == node_address;
    fc_inc    = (item.forward_count == 8'hFF) ? 8'hFF : item.forward_count + 8'd1;
    size_sum  = {1'b0, item.packet_bytes} + {9'b0, route_header_bytes};
    // originating packet grows by the header, saturating
    if (from_here) begin
      size_new = size_sum[16] ? 16'hFFFF : size_sum[15:0];
    end else begin
      size_new = item.packet_bytes;
    end
    for_here  = item.destination_address == ADDR_BROADCAST
             || item.destination_address == node_address;
    route_hit = entry.valid && addr_in_table(item.destination_address, TABLE_ENTRIES);

    result = '0;
    if (item.action == ACTION_ROUTE) begin
      result.verdict      = VERDICT_ROUTE_ACK;
      result.route_stored = item.route_owner == node_address
                         && addr_in_table(item.route_destination, TABLE_ENTRIES);
    end else if (from_here && item.forward_count != 8'd0) begin
      result.verdict = VERDICT_DROP_LOOP;
    end else if (!from_here && item.incoming_next_hop != node_address) begin
      result.verdict = VERDICT_NOT_MINE;
    end else if (item.going_up && for_here) begin
      result.verdict           = VERDICT_DELIVER;
      result.outgoing_next_hop = item.incoming_next_hop;
      result.new_forward_count = fc_inc;
      result.new_packet_bytes  = size_new;
    end else if (item.destination_address == ADDR_BROADCAST) begin
      result.verdict           = VERDICT_FORWARD;
      result.outgoing_next_hop = ADDR_BROADCAST;
      result.new_forward_count = fc_inc;
      result.new_packet_bytes  = size_new;
    end else if (route_hit) begin
      result.verdict           = VERDICT_FORWARD;
      result.outgoing_next_hop = entry.hop;
      result.new_forward_count = fc_inc;
      result.new_packet_bytes  = size_new;
    end else begin
      result.verdict = VERDICT_NO_ROUTE;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/static_next_hop_forwarder_top.sv =====
// static next-hop forwarder: an accepted item and its table word are registered in s1,
// then the decided result is registered in rsp, where rsp_valid marks it
// throughput one item per cycle while rsp_stall is low, set by the single table port
// used once per item; after reset the hop table is swept clear one word at a time,
// with req_stall held high; configuration writes are taken during the sweep
// reset sets node_address and route_header_bytes to 0
// depends on snhf_pkg, snhf_ram, snhf_decide
`default_nettype none

module static_next_hop_forwarder_top
  import snhf_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // request channel
  input  wire logic                       req_valid,
  output logic                            req_stall,
  input  wire req_item_t                  req,
  // result channel
  output logic                            rsp_valid,
  input  wire logic                       rsp_stall,
  output rsp_item_t                       rsp,
  // configuration write port
  input  wire logic                       cfg_write,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [AW-1:0] LAST_INDEX = AW'(TABLE_ENTRIES - 1);

  // configuration registers
  logic [7:0] node_address;
  logic [7:0] route_header_bytes;

  // table clear sweep after reset
  logic          clearing;
  logic [AW-1:0] clear_addr;

  // item register in front of the decision logic
  logic      s1_valid;
  req_item_t s1_item;
  logic      s1_move;

  // table port
  logic       accept;
  logic       ram_en;
  logic       ram_we;
  logic [AW-1:0] ram_addr;
  hop_entry_t ram_wdata;
  hop_entry_t ram_rdata;
  logic [7:0] key_addr;
  logic [16:0] key_ext;
  logic       route_write;

  rsp_item_t decided;

  // an item enters when valid and not stalled; the table is read or written then,
  // so the word arrives alongside the item in the next cycle
  assign accept    = req_valid && !req_stall;
  assign s1_move   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = clearing || (s1_valid && !s1_move);

  always_comb begin
    // route writes address the table by route destination, packets by destination
    key_addr    = (req.action == ACTION_ROUTE) ? req.route_destination
                                               : req.destination_address;
    key_ext     = {9'b0, key_addr};
    route_write = req.action == ACTION_ROUTE
               && req.route_owner == node_address
               && addr_in_table(req.route_destination, TABLE_ENTRIES);

    ram_en = clearing || accept;
    ram_we = clearing || (accept && route_write);
    if (clearing) begin
      ram_addr  = clear_addr;
      ram_wdata = '0;
    end else begin
      ram_addr        = key_ext[AW-1:0];
      ram_wdata.valid = 1'b1;
      ram_wdata.hop   = req.route_hop;
    end
  end

  snhf_ram #(
    .WIDTH ($bits(hop_entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_hop_table (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  snhf_decide #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_decide (
    .item               (s1_item),
    .entry              (ram_rdata),
    .node_address       (node_address),
    .route_header_bytes (route_header_bytes),
    .result             (decided)
  );

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      node_address       <= '0;
      route_header_bytes <= '0;
      clearing           <= 1'b1;
      clear_addr         <= '0;
      s1_valid           <= 1'b0;
      rsp_valid          <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_NODE_ADDRESS:       node_address       <= cfg_data;
          CFG_ROUTE_HEADER_BYTES: route_header_bytes <= cfg_data;
          default: ;
        endcase
      end
      // sweep one table word a cycle
      if (clearing) begin
        if (clear_addr == LAST_INDEX) begin
          clearing <= 1'b0;
        end
        clear_addr <= clear_addr + AW'(1);
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= req;
    end
    if (s1_move) begin
      rsp <= decided;
    end
  end

endmodule

`default_nettype wire
